// ===== hw/rtl/lcdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdt_pkg
// Shared types, register codes and timing constants for the LCD mode and
// scanline timing sequencer.
// ----------------------------------------------------------------------------
package lcdt_pkg;

    // item command codes
    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_WRITE   = 1'b1;

    // register select codes
    localparam logic [1:0] REG_CONTROL = 2'd0;
    localparam logic [1:0] REG_STATUS  = 2'd1;
    localparam logic [1:0] REG_LINE    = 2'd2;
    localparam logic [1:0] REG_COMPARE = 2'd3;

    // display modes
    localparam logic [1:0] MODE_LINE_BLANK  = 2'd0;
    localparam logic [1:0] MODE_FRAME_BLANK = 2'd1;
    localparam logic [1:0] MODE_OAM         = 2'd2;
    localparam logic [1:0] MODE_XFER        = 2'd3;

    // status register bit positions
    localparam int STAT_COINC     = 2;
    localparam int STAT_HBLANK_EN = 3;
    localparam int STAT_VBLANK_EN = 4;
    localparam int STAT_OAM_EN    = 5;
    localparam int STAT_COINC_EN  = 6;
    localparam logic [7:0] STAT_KEEP_MASK  = 8'h87;
    localparam logic [7:0] STAT_WRITE_MASK = 8'h78;
    localparam logic [7:0] STAT_WRITTEN    = 8'h80;

    // control register
    localparam int         CTRL_ENABLE   = 7;
    localparam logic [7:0] CTRL_ENABLE_M = 8'h80;
    localparam logic [7:0] CTRL_RESET    = 8'h91;
    localparam logic [7:0] STAT_RESET    = 8'h06;

    // mode budgets in ticks
    localparam logic signed [15:0] OAM_TICKS    = 16'sd80;
    localparam logic signed [15:0] XFER_TICKS   = 16'sd172;
    localparam logic signed [15:0] HBLANK_TICKS = 16'sd204;
    localparam logic signed [15:0] VBLANK_TICKS = 16'sd4560;
    localparam int                 LINE_TICKS   = 456;

    // tick budget limits (14 bit signed)
    localparam logic signed [15:0] BUDGET_MAX = 16'sd8191;
    localparam logic signed [15:0] BUDGET_MIN = -16'sd8192;
    localparam logic signed [13:0] ENABLE_START = -14'sd4;

    // line numbers
    localparam logic [7:0] LAST_VISIBLE_LINE = 8'd143;
    localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;

    typedef logic signed [13:0] budget_t;
    typedef logic signed [9:0]  line_ticks_t;

    typedef struct packed {
        logic       command;
        logic [1:0] reg_select;
        logic [7:0] write_data;
        logic [7:0] tick_count;
    } item_t;

    typedef struct packed {
        logic [7:0] status_value;
        logic [7:0] line_value;
        logic [7:0] control_value;
        logic       vblank_request;
        logic       lcd_stat_request;
        logic       vram_locked;
        logic       oam_locked;
    } result_t;

    // saturating add into the 14 bit tick budget
    function automatic budget_t sat_add(input budget_t a, input logic signed [15:0] d);
        logic signed [15:0] s;
        s = $signed({{2{a[13]}}, a}) + d;
        if (s > BUDGET_MAX)
        begin
            return BUDGET_MAX[13:0];
        end
        else if (s < BUDGET_MIN)
        begin
            return BUDGET_MIN[13:0];
        end
        return s[13:0];
    endfunction

endpackage

// ===== hw/rtl/lcdt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdt_if
// Valid/ready channels for sequencer requests and results.
// ----------------------------------------------------------------------------
interface lcdt_item_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [1:0] reg_select;
    logic [7:0] write_data;
    logic [7:0] tick_count;

    modport source (output valid, command, reg_select, write_data, tick_count,
                    input ready);
    modport sink (input valid, command, reg_select, write_data, tick_count,
                  output ready);
endinterface

interface lcdt_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_value;
    logic [7:0] line_value;
    logic [7:0] control_value;
    logic       vblank_request;
    logic       lcd_stat_request;
    logic       vram_locked;
    logic       oam_locked;

    modport source (output valid, status_value, line_value, control_value,
                    vblank_request, lcd_stat_request, vram_locked, oam_locked,
                    input ready);
    modport sink (input valid, status_value, line_value, control_value,
                  vblank_request, lcd_stat_request, vram_locked, oam_locked,
                  output ready);
endinterface

// ===== hw/rtl/lcd_mode_timing_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_mode_timing_sequencer_unit
// LCD mode and scanline timing sequencer: advances display time or writes
// control, status, line counter and line compare, one request at a time.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  ---------+-----------+----------------------------------------------------
//  item     | in        | command, reg_select, write_data, tick_count
//  result   | out       | status, line, control, interrupt requests, locks
//
//  one request per cycle sustained while results are taken; a request
//  passes the request register, then its result the result register
//  reset: display on, oam search with 80 ticks, LY 0, control 0x91,
//  status 0x06
//  a stalled result holds in its register; the request register still
//  fills, then ready drops until the result is taken
// ----------------------------------------------------------------------------
module lcd_mode_timing_sequencer_unit
    import lcdt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lcdt_item_if.sink     item,
    lcdt_result_if.source result
);

    logic    item_valid_reg, item_valid_next;
    item_t   item_reg;
    logic    res_valid_reg, res_valid_next;
    result_t res_reg;
    result_t seq_res;
    logic    step;
    logic    take;

    // handshake
    assign step       = item_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || step;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (take)
        begin
            item_valid_next = 1'b1;
        end
        else if (step)
        begin
            item_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (step)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.command    <= item.command;
            item_reg.reg_select <= item.reg_select;
            item_reg.write_data <= item.write_data;
            item_reg.tick_count <= item.tick_count;
        end
        if (step)
        begin
            res_reg <= seq_res;
        end
    end

    // sequencer state and next-state logic
    lcdt_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cur   (item_reg),
        .res   (seq_res)
    );

    // result port
    assign result.valid            = res_valid_reg;
    assign result.status_value     = res_reg.status_value;
    assign result.line_value       = res_reg.line_value;
    assign result.control_value    = res_reg.control_value;
    assign result.vblank_request   = res_reg.vblank_request;
    assign result.lcd_stat_request = res_reg.lcd_stat_request;
    assign result.vram_locked      = res_reg.vram_locked;
    assign result.oam_locked       = res_reg.oam_locked;

endmodule

// ===== hw/rtl/lcdt_line_rem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdt_line_rem
// Remainder of the vblank tick budget by the line length, truncated toward
// zero, with a zero remainder mapped to a full line.
// ----------------------------------------------------------------------------
module lcdt_line_rem
    import lcdt_pkg::*;
(
    input  budget_t     budget,
    output line_ticks_t line_ticks
);

    localparam int MAX_MULT = 8192 / LINE_TICKS;

    logic [13:0] mag;
    logic [13:0] sub;
    logic [8:0]  rem;

    // magnitude, then the largest line multiple not above it
    always_comb
    begin
        mag = budget[13] ? 14'(-budget) : budget;
        sub = '0;
        for (int k = 1; k <= MAX_MULT; k++)
        begin
            if (mag >= 14'(k * LINE_TICKS))
            begin
                sub = 14'(k * LINE_TICKS);
            end
        end
        rem = 9'(mag - sub);
    end

    // restore sign, empty remainder gives a full line
    always_comb
    begin
        if (rem == 9'd0)
        begin
            line_ticks = 10'(LINE_TICKS);
        end
        else if (budget[13])
        begin
            line_ticks = -$signed({1'b0, rem});
        end
        else
        begin
            line_ticks = $signed({1'b0, rem});
        end
    end

endmodule

// ===== hw/rtl/lcdt_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdt_seq
// Mode and scanline state with the single-pass next-state logic for one
// advance or register write request.
// ----------------------------------------------------------------------------
module lcdt_seq
    import lcdt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   cur,
    output result_t res
);

    logic        disp_reg,  disp_next;
    logic [1:0]  mode_reg,  mode_next;
    logic [7:0]  line_reg,  line_next;
    logic [7:0]  lyc_reg,   lyc_next;
    logic [7:0]  ctrl_reg,  ctrl_next;
    logic [7:0]  stat_reg,  stat_next;
    budget_t     mtl_reg,   mtl_next;
    line_ticks_t vl_reg,    vl_next;

    logic               vbreq;
    logic               streq;
    logic signed [15:0] neg_ticks;
    logic signed [10:0] vl_dec;
    logic signed [10:0] vl_wrap;
    budget_t            vbl_budget;
    line_ticks_t        vbl_line_ticks;

    // operands shared by the advance paths
    assign neg_ticks  = -$signed({8'h00, cur.tick_count});
    assign vl_dec     = $signed({vl_reg[9], vl_reg}) - $signed({3'b000, cur.tick_count});
    assign vl_wrap    = vl_dec + 11'(LINE_TICKS);
    assign vbl_budget = sat_add(sat_add(mtl_reg, neg_ticks), VBLANK_TICKS);

    lcdt_line_rem u_line_rem
    (
        .budget     (vbl_budget),
        .line_ticks (vbl_line_ticks)
    );

    // next state for one request
    always_comb
    begin
        disp_next = disp_reg;
        mode_next = mode_reg;
        line_next = line_reg;
        lyc_next  = lyc_reg;
        ctrl_next = ctrl_reg;
        stat_next = stat_reg;
        mtl_next  = mtl_reg;
        vl_next   = vl_reg;
        vbreq     = 1'b0;
        streq     = 1'b0;

        if (cur.command == CMD_ADVANCE)
        begin
            if (disp_reg)
            begin
                // vblank line stepping
                if (mode_reg == MODE_FRAME_BLANK)
                begin
                    if (vl_dec <= 11'sd0)
                    begin
                        line_next = line_next + 8'd1;
                        vl_next   = vl_wrap[9:0];
                        stat_next[STAT_COINC] = (line_next == lyc_reg);
                        streq = streq | ((line_next == lyc_reg) & stat_next[STAT_COINC_EN]);
                    end
                    else
                    begin
                        vl_next = vl_dec[9:0];
                    end
                end

                // mode budget and transition
                mtl_next = sat_add(mtl_reg, neg_ticks);
                if (mtl_next <= 14'sd0)
                begin
                    case (mode_reg)
                        MODE_OAM:
                        begin
                            mtl_next  = sat_add(mtl_next, XFER_TICKS);
                            mode_next = MODE_XFER;
                        end
                        MODE_XFER:
                        begin
                            mtl_next  = sat_add(mtl_next, HBLANK_TICKS);
                            mode_next = MODE_LINE_BLANK;
                            streq     = streq | stat_next[STAT_HBLANK_EN];
                        end
                        default:
                        begin
                            if (line_next == LAST_VISIBLE_LINE)
                            begin
                                mtl_next  = vbl_budget;
                                line_next = FIRST_VBLANK_LINE;
                                stat_next[STAT_COINC] = (line_next == lyc_reg);
                                streq = streq | ((line_next == lyc_reg)
                                                 & stat_next[STAT_COINC_EN]);
                                vl_next   = vbl_line_ticks;
                                mode_next = MODE_FRAME_BLANK;
                                vbreq     = 1'b1;
                                streq     = streq | stat_next[STAT_VBLANK_EN];
                            end
                            else
                            begin
                                mtl_next  = sat_add(mtl_next, OAM_TICKS);
                                line_next = line_next + 8'd1;
                                if (line_next >= FIRST_VBLANK_LINE)
                                begin
                                    line_next = '0;
                                end
                                stat_next[STAT_COINC] = (line_next == lyc_reg);
                                streq = streq | ((line_next == lyc_reg)
                                                 & stat_next[STAT_COINC_EN]);
                                mode_next = MODE_OAM;
                                streq     = streq | stat_next[STAT_OAM_EN];
                            end
                        end
                    endcase
                end
            end
        end
        else
        begin
            case (cur.reg_select)
                REG_CONTROL:
                begin
                    ctrl_next = cur.write_data;
                    if (cur.write_data[CTRL_ENABLE])
                    begin
                        // enable from off starts line 0 oam search
                        if (!disp_reg)
                        begin
                            mtl_next  = sat_add(ENABLE_START, OAM_TICKS);
                            line_next = '0;
                            mode_next = MODE_OAM;
                            streq     = streq | stat_next[STAT_OAM_EN];
                        end
                        disp_next = 1'b1;
                    end
                    else if (mode_reg == MODE_FRAME_BLANK)
                    begin
                        // disable only takes effect in vblank
                        mode_next = MODE_LINE_BLANK;
                        streq     = streq | stat_next[STAT_HBLANK_EN];
                        line_next = '0;
                        mtl_next  = '0;
                        if (disp_reg)
                        begin
                            stat_next[STAT_COINC] = (lyc_reg == 8'd0);
                            streq = streq | ((lyc_reg == 8'd0) & stat_next[STAT_COINC_EN]);
                        end
                        disp_next = 1'b0;
                    end
                end
                REG_STATUS:
                begin
                    if (cur.write_data[STAT_COINC])
                    begin
                        stat_next[STAT_COINC] = 1'b0;
                    end
                    stat_next = (stat_next & STAT_KEEP_MASK)
                              | (cur.write_data & STAT_WRITE_MASK) | STAT_WRITTEN;
                    if (disp_reg)
                    begin
                        stat_next[STAT_COINC] = (line_reg == lyc_reg);
                        streq = streq | ((line_reg == lyc_reg) & stat_next[STAT_COINC_EN]);
                    end
                end
                REG_LINE:
                begin
                    // forced disable through hblank, then enable at line 0
                    ctrl_next = ctrl_reg | CTRL_ENABLE_M;
                    streq     = streq | stat_next[STAT_HBLANK_EN];
                    if (disp_reg)
                    begin
                        stat_next[STAT_COINC] = (lyc_reg == 8'd0);
                        streq = streq | ((lyc_reg == 8'd0) & stat_next[STAT_COINC_EN]);
                    end
                    mtl_next  = sat_add(ENABLE_START, OAM_TICKS);
                    line_next = '0;
                    mode_next = MODE_OAM;
                    streq     = streq | stat_next[STAT_OAM_EN];
                    disp_next = 1'b1;
                end
                REG_COMPARE:
                begin
                    lyc_next = cur.write_data;
                end
                default:
                begin
                    lyc_next = lyc_reg;
                end
            endcase
        end

        // mode bits track the mode
        stat_next[1:0] = mode_next;
    end

    // result of this request
    always_comb
    begin
        res.status_value     = stat_next;
        res.line_value       = line_next;
        res.control_value    = ctrl_next;
        res.vblank_request   = vbreq;
        res.lcd_stat_request = streq;
        res.vram_locked      = (mode_next == MODE_XFER);
        res.oam_locked       = (mode_next == MODE_XFER) || (mode_next == MODE_OAM);
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_reg <= 1'b1;
            mode_reg <= MODE_OAM;
            line_reg <= '0;
            lyc_reg  <= '0;
            ctrl_reg <= CTRL_RESET;
            stat_reg <= STAT_RESET;
            mtl_reg  <= OAM_TICKS[13:0];
            vl_reg   <= '0;
        end
        else if (step)
        begin
            disp_reg <= disp_next;
            mode_reg <= mode_next;
            line_reg <= line_next;
            lyc_reg  <= lyc_next;
            ctrl_reg <= ctrl_next;
            stat_reg <= stat_next;
            mtl_reg  <= mtl_next;
            vl_reg   <= vl_next;
        end
    end

endmodule
